### hdl/bse_pkg.sv
package bse_pkg;

  localparam int MV_W            = 16;
  localparam int PCT_W           = 7;
  localparam int DEN_W           = 8;
  localparam int IDX_W           = 8;
  localparam int CURVE_POINTS    = 12;
  localparam int SEG_W           = 4;
  localparam int STEP_PCT_W      = 4;
  localparam int PROD_W          = 12;
  localparam int SAMPLES_DEFAULT = 8;

  localparam logic [IDX_W-1:0] REG_MIN_MV = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_MAX_MV = IDX_W'(1);

  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_AVG,
    ST_CHECK,
    ST_MUL,
    ST_START_PCT,
    ST_DIV_PCT,
    ST_SMOOTH,
    ST_OUT
  } back_state_e;

  typedef struct packed {
    logic             reading_valid;
    logic [MV_W-1:0]  average_mv;
    logic [PCT_W-1:0] curve_percent;
    logic [PCT_W-1:0] shown_percent;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Discharge curve, highest point first.
  function automatic logic [MV_W-1:0] curve_mv(input logic [SEG_W-1:0] k);
    logic [MV_W-1:0] v;
    unique case (k)
      4'd0:    v = 16'd4200;
      4'd1:    v = 16'd4100;
      4'd2:    v = 16'd4000;
      4'd3:    v = 16'd3930;
      4'd4:    v = 16'd3870;
      4'd5:    v = 16'd3820;
      4'd6:    v = 16'd3790;
      4'd7:    v = 16'd3770;
      4'd8:    v = 16'd3740;
      4'd9:    v = 16'd3680;
      4'd10:   v = 16'd3450;
      4'd11:   v = 16'd3200;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [PCT_W-1:0] curve_pct(input logic [SEG_W-1:0] k);
    logic [PCT_W-1:0] v;
    unique case (k)
      4'd0:    v = 7'd100;
      4'd1:    v = 7'd90;
      4'd2:    v = 7'd80;
      4'd3:    v = 7'd70;
      4'd4:    v = 7'd60;
      4'd5:    v = 7'd50;
      4'd6:    v = 7'd40;
      4'd7:    v = 7'd30;
      4'd8:    v = 7'd20;
      4'd9:    v = 7'd10;
      4'd10:   v = 7'd5;
      4'd11:   v = 7'd0;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

endpackage

### hdl/bse_if.sv
interface bse_sample_if;
  import bse_pkg::*;
  logic            valid;
  logic            ready;
  logic [MV_W-1:0] sample_mv;
  modport source (output valid, output sample_mv, input ready);
  modport sink   (input valid, input sample_mv, output ready);
endinterface

interface bse_cfg_if;
  import bse_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [MV_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface bse_result_if;
  import bse_pkg::*;
  logic             valid;
  logic             ready;
  logic             reading_valid;
  logic [MV_W-1:0]  average_mv;
  logic [PCT_W-1:0] curve_percent;
  logic [PCT_W-1:0] shown_percent;
  modport source (output valid, output reading_valid, output average_mv,
                  output curve_percent, output shown_percent, input ready);
  modport sink   (input valid, input reading_valid, input average_mv,
                  input curve_percent, input shown_percent, output ready);
endinterface

### hdl/bse_front.sv
module bse_front #(
  parameter int SAMPLES_PER_READING = bse_pkg::SAMPLES_DEFAULT,
  parameter int SUM_W               = bse_pkg::MV_W + 4,
  parameter int CNT_W               = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        sample_valid_i,
  input  logic [bse_pkg::MV_W-1:0]    sample_mv_i,
  output logic                        sample_ready_o,
  input  logic                        full_i,
  output logic                        push_o,
  output logic [SUM_W+CNT_W-1:0]      push_data_o
);
  import bse_pkg::*;

  localparam int POS_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(SAMPLES_PER_READING - 1);

  logic [SUM_W-1:0] sum_q, sum_d, sum_add;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_add;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             last, accept, nonzero;

  assign last           = (pos_q == POS_LAST);
  assign sample_ready_o = !(last && full_i);
  assign accept         = sample_valid_i && sample_ready_o;
  assign nonzero        = (sample_mv_i != '0);

  assign sum_add = sum_q + (nonzero ? SUM_W'(sample_mv_i) : '0);
  assign cnt_add = cnt_q + (nonzero ? CNT_W'(1) : '0);

  assign push_o      = accept && last;
  assign push_data_o = {sum_add, cnt_add};

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    pos_d = pos_q;
    if (accept) begin
      if (last) begin
        sum_d = '0;
        cnt_d = '0;
        pos_d = '0;
      end else begin
        sum_d = sum_add;
        cnt_d = cnt_add;
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      pos_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      pos_q <= pos_d;
    end
  end

endmodule

### hdl/bse_fifo.sv
module bse_fifo #(
  parameter int W = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  input  logic         pop_i,
  output logic [W-1:0] pop_data_o,
  output logic         full_o,
  output logic         empty_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   level_q;

  assign full_o     = (level_q == 2'd2);
  assign empty_o    = (level_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      level_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      unique case ({push_i, pop_i})
        2'b10:   level_q <= level_q + 2'd1;
        2'b01:   level_q <= level_q - 2'd1;
        default: level_q <= level_q;
      endcase
    end
  end

endmodule

### hdl/bse_div.sv
module bse_div #(
  parameter int NUM_W = 20
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [NUM_W-1:0]          num_i,
  input  logic [bse_pkg::DEN_W-1:0] den_i,
  output logic [NUM_W-1:0]          quo_o,
  output bse_pkg::div_status_t      status_o
);
  import bse_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0]  rem_q, den_q;
  logic [NUM_W-1:0]  quo_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q, done_q;
  logic [DEN_W:0]    trial;
  logic              fits;

  // Restoring divide, one quotient bit per cycle.
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  assign quo_o         = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(NUM_W);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

### hdl/bse_back.sv
module bse_back #(
  parameter int SUM_W = bse_pkg::MV_W + 4,
  parameter int CNT_W = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     empty_i,
  input  logic [SUM_W+CNT_W-1:0]   pop_data_i,
  output logic                     pop_o,
  input  logic [bse_pkg::MV_W-1:0] min_mv_i,
  input  logic [bse_pkg::MV_W-1:0] max_mv_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output bse_pkg::result_t         result_o
);
  import bse_pkg::*;

  back_state_e         state_q, state_d;
  logic [SUM_W-1:0]    win_sum;
  logic [CNT_W-1:0]    win_cnt;
  logic                div_start;
  logic [SUM_W-1:0]    div_num, div_quo;
  logic [DEN_W-1:0]    div_den;
  div_status_t         div_st;

  logic [MV_W-1:0]     avg_q;
  logic [SEG_W-1:0]    seg_q, seg_prev, seg_hit;
  logic                seg_found;
  logic [PROD_W-1:0]   prod_q;
  logic [PCT_W-1:0]    pct_q, sm_pct_q, sm_next;
  logic                sm_valid_q;
  result_t             res_q;
  logic                invalid, at_top;
  logic [MV_W-1:0]     diff_mv, span_mv;
  logic [PCT_W-1:0]    pct_step;

  assign {win_sum, win_cnt} = pop_data_i;

  assign invalid  = (avg_q < min_mv_i) || (avg_q > max_mv_i);
  assign at_top   = (avg_q >= curve_mv(SEG_W'(0)));
  assign seg_prev = seg_q - SEG_W'(1);
  assign diff_mv  = avg_q - curve_mv(seg_q);
  assign span_mv  = curve_mv(seg_prev) - curve_mv(seg_q);
  assign pct_step = curve_pct(seg_prev) - curve_pct(seg_q);

  // First curve point at or below the average; descending scan keeps the lowest index.
  always_comb begin
    seg_hit   = '0;
    seg_found = 1'b0;
    for (int k = CURVE_POINTS - 1; k >= 1; k--) begin
      if (avg_q >= curve_mv(SEG_W'(k))) begin
        seg_hit   = SEG_W'(k);
        seg_found = 1'b1;
      end
    end
  end

  always_comb begin
    if (!sm_valid_q)          sm_next = pct_q;
    else if (pct_q > sm_pct_q) sm_next = sm_pct_q + PCT_W'(1);
    else if (pct_q < sm_pct_q) sm_next = sm_pct_q - PCT_W'(1);
    else                       sm_next = sm_pct_q;
  end

  bse_div #(.NUM_W(SUM_W)) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .quo_o    (div_quo),
    .status_o (div_st)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) state_d = (win_cnt == '0) ? ST_CHECK : ST_DIV_AVG;
      end
      ST_DIV_AVG: begin
        if (div_st.done) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (invalid)                 state_d = ST_OUT;
        else if (at_top || !seg_found) state_d = ST_SMOOTH;
        else                         state_d = ST_MUL;
      end
      ST_MUL:       state_d = ST_START_PCT;
      ST_START_PCT: state_d = ST_DIV_PCT;
      ST_DIV_PCT: begin
        if (div_st.done) state_d = ST_SMOOTH;
      end
      ST_SMOOTH:    state_d = ST_OUT;
      ST_OUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    pop_o       = 1'b0;
    div_start   = 1'b0;
    div_num     = win_sum;
    div_den     = DEN_W'(win_cnt);
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        pop_o     = !empty_i;
        div_start = !empty_i && (win_cnt != '0);
      end
      ST_START_PCT: begin
        div_start = 1'b1;
        div_num   = SUM_W'(prod_q);
        div_den   = span_mv[DEN_W-1:0];
      end
      ST_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign result_o = res_q;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i && win_cnt == '0) avg_q <= '0;
      end
      ST_DIV_AVG: begin
        if (div_st.done) avg_q <= div_quo[MV_W-1:0];
      end
      ST_CHECK: begin
        seg_q <= seg_hit;
        pct_q <= at_top ? PCT_FULL : '0;
        if (invalid) begin
          res_q.reading_valid <= 1'b0;
          res_q.average_mv    <= avg_q;
          res_q.curve_percent <= '0;
          res_q.shown_percent <= '0;
        end
      end
      ST_MUL: begin
        prod_q <= PROD_W'(diff_mv[DEN_W-1:0]) * PROD_W'(pct_step[STEP_PCT_W-1:0]);
      end
      ST_DIV_PCT: begin
        if (div_st.done) pct_q <= curve_pct(seg_q) + div_quo[PCT_W-1:0];
      end
      ST_SMOOTH: begin
        res_q.reading_valid <= 1'b1;
        res_q.average_mv    <= avg_q;
        res_q.curve_percent <= pct_q;
        res_q.shown_percent <= sm_next;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      sm_pct_q   <= '0;
      sm_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CHECK && invalid) begin
        sm_pct_q   <= '0;
        sm_valid_q <= 1'b0;
      end else if (state_q == ST_SMOOTH) begin
        sm_pct_q   <= sm_next;
        sm_valid_q <= 1'b1;
      end
    end
  end

endmodule

### hdl/battery_soc_estimator.sv
// Battery state-of-charge estimator for a single lithium cell.
// Channels: sample_i carries one voltage sample (mV) per request, zero
// meaning a failed sample; result_o carries one reading per window of
// SAMPLES_PER_READING samples; cfg_i writes the plausible window bounds
// (index 0 = min mV, index 1 = max mV, other indexes ignored, always ready).
// The front accumulates samples at one per cycle, holding a window's last
// sample while the queue is full, and hands each finished window (sum,
// nonzero count) to a two-entry queue. The back pops a window, averages it
// on a shared bit-serial divider, checks the plausible window, interpolates
// on the 12-point curve (multiply, then the same divider) and applies the
// one-point slew limit to the shown percent. The divider gives one quotient
// bit per cycle over SUM_W = 16 + clog2(N+1) bits; a reading that skips a
// divider pass comes out sooner. The front takes the next window's samples
// while the back is still working on the last one.
// Reset clears the accumulator, queue, slew state and restores the bounds
// to 2500/4500 mV. When the receiver stalls, the result holds in the back's
// output register; the front keeps taking samples until the queue is full
// and the current window's last sample arrives.
module battery_soc_estimator #(
  parameter int SAMPLES_PER_READING = bse_pkg::SAMPLES_DEFAULT
) (
  input logic          clk_i,
  input logic          rst_ni,
  bse_sample_if.sink   sample_i,
  bse_cfg_if.sink      cfg_i,
  bse_result_if.source result_o
);
  import bse_pkg::*;

  // Sum and count widths follow the window length.
  localparam int CNT_W = $clog2(SAMPLES_PER_READING + 1);
  localparam int SUM_W = MV_W + CNT_W;
  localparam int WIN_W = SUM_W + CNT_W;

  logic [MV_W-1:0]  min_mv_q, max_mv_q;
  logic             win_push, fifo_full, fifo_empty, fifo_pop;
  logic [WIN_W-1:0] win_data, fifo_data;
  result_t          res;

  // Configuration writes, taken every cycle.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_mv_q <= MV_W'(2500);
      max_mv_q <= MV_W'(4500);
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_MIN_MV) min_mv_q <= cfg_i.data;
      if (cfg_i.index == REG_MAX_MV) max_mv_q <= cfg_i.data;
    end
  end

  bse_front #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING),
    .SUM_W               (SUM_W),
    .CNT_W               (CNT_W)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_i.valid),
    .sample_mv_i    (sample_i.sample_mv),
    .sample_ready_o (sample_i.ready),
    .full_i         (fifo_full),
    .push_o         (win_push),
    .push_data_o    (win_data)
  );

  // Window queue between front and back.
  bse_fifo #(.W(WIN_W)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (win_push),
    .push_data_i (win_data),
    .pop_i       (fifo_pop),
    .pop_data_o  (fifo_data),
    .full_o      (fifo_full),
    .empty_o     (fifo_empty)
  );

  bse_back #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (fifo_empty),
    .pop_data_i  (fifo_data),
    .pop_o       (fifo_pop),
    .min_mv_i    (min_mv_q),
    .max_mv_i    (max_mv_q),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .result_o    (res)
  );

  assign result_o.reading_valid = res.reading_valid;
  assign result_o.average_mv    = res.average_mv;
  assign result_o.curve_percent = res.curve_percent;
  assign result_o.shown_percent = res.shown_percent;

  // A finished window never lands on a full queue.
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(win_push && fifo_full))
    else $error("window pushed into full queue");

  // Windows only close on an accepted sample.
  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_push |-> (sample_i.valid && sample_i.ready))
    else $error("window push without sample request");

  // Invalid readings carry zero percents.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.reading_valid) |->
      (result_o.curve_percent == '0 && result_o.shown_percent == '0))
    else $error("invalid reading with nonzero percent");

  // Percents stay on the curve's range.
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |->
      (result_o.curve_percent <= PCT_FULL && result_o.shown_percent <= PCT_FULL))
    else $error("percent above full scale");

endmodule

### test/bse_reading_checker.sv
`timescale 1ns / 1ps

// Watches the three channels, keeps its own copy of the estimator state and
// compares every reading taken from the block with the oldest one it predicted.
module bse_reading_checker #(
  parameter int SAMPLES_PER_READING = bse_pkg::SAMPLES_DEFAULT
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  bse_sample_if sample_mon,
  bse_cfg_if    cfg_mon,
  bse_result_if result_mon,
  output int    mismatches_o,
  output int    pending_o
);
  import bse_pkg::*;

  // Discharge knees, highest first.
  localparam int unsigned KNEE_MV[CURVE_POINTS] = '{
    4200, 4100, 4000, 3930, 3870, 3820, 3790, 3770, 3740, 3680, 3450, 3200
  };
  localparam int unsigned KNEE_PCT[CURVE_POINTS] = '{
    100, 90, 80, 70, 60, 50, 40, 30, 20, 10, 5, 0
  };

  logic [MV_W-1:0] floor_mv;
  logic [MV_W-1:0] ceil_mv;
  int unsigned     window_sum;
  int unsigned     window_taken;
  int unsigned     window_live;
  int unsigned     shown_pct;
  bit              shown_live;
  result_t         readings_due[$];
  int              mismatches;

  function automatic int unsigned percent_of(input int unsigned mv);
    if (mv >= KNEE_MV[0]) return 100;
    for (int k = 1; k < CURVE_POINTS; k++) begin
      if (mv >= KNEE_MV[k])
        return KNEE_PCT[k] + ((mv - KNEE_MV[k]) * (KNEE_PCT[k-1] - KNEE_PCT[k])) /
               (KNEE_MV[k-1] - KNEE_MV[k]);
    end
    return 0;
  endfunction

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= 50) $display("%0t ns: %s", $time, what);
  endtask

  task automatic take_sample(input logic [MV_W-1:0] mv);
    int unsigned avg;
    int unsigned pct;
    result_t     r;
    if (mv != '0) begin
      window_sum += mv;
      window_live++;
    end
    window_taken++;
    if (window_taken < SAMPLES_PER_READING) return;
    avg          = (window_live != 0) ? window_sum / window_live : 0;
    window_sum   = 0;
    window_live  = 0;
    window_taken = 0;
    r.average_mv = avg[MV_W-1:0];
    if (avg < floor_mv || avg > ceil_mv) begin
      // implausible: clear the slew state
      shown_pct       = 0;
      shown_live      = 1'b0;
      r.reading_valid = 1'b0;
      r.curve_percent = '0;
      r.shown_percent = '0;
    end else begin
      pct = percent_of(avg);
      if (!shown_live) begin
        shown_pct  = pct;
        shown_live = 1'b1;
      end else if (pct > shown_pct) begin
        shown_pct++;
      end else if (pct < shown_pct) begin
        shown_pct--;
      end
      r.reading_valid = 1'b1;
      r.curve_percent = pct[PCT_W-1:0];
      r.shown_percent = shown_pct[PCT_W-1:0];
    end
    readings_due.push_back(r);
  endtask

  task automatic check_reading(input logic rv, input logic [MV_W-1:0] avg,
                               input logic [PCT_W-1:0] curve, input logic [PCT_W-1:0] shown);
    result_t want;
    if (readings_due.size() == 0) begin
      report($sformatf("reading with none due: valid=%0d avg=%0d", rv, avg));
      return;
    end
    want = readings_due.pop_front();
    if (rv !== want.reading_valid)
      report($sformatf("reading_valid %0d, want %0d", rv, want.reading_valid));
    if (avg !== want.average_mv)
      report($sformatf("average_mv %0d, want %0d", avg, want.average_mv));
    if (curve !== want.curve_percent)
      report($sformatf("curve_percent %0d, want %0d (avg %0d)", curve,
                       want.curve_percent, want.average_mv));
    if (shown !== want.shown_percent)
      report($sformatf("shown_percent %0d, want %0d (avg %0d)", shown,
                       want.shown_percent, want.average_mv));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_mv     = 16'd2500;
      ceil_mv      = 16'd4500;
      window_sum   = 0;
      window_taken = 0;
      window_live  = 0;
      shown_pct    = 0;
      shown_live   = 1'b0;
      mismatches   = 0;
      readings_due.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_MIN_MV) floor_mv = cfg_mon.data;
        else if (cfg_mon.index == REG_MAX_MV) ceil_mv = cfg_mon.data;
      end
      if (sample_mon.valid && sample_mon.ready) take_sample(sample_mon.sample_mv);
      if (result_mon.valid && result_mon.ready)
        check_reading(result_mon.reading_valid, result_mon.average_mv,
                      result_mon.curve_percent, result_mon.shown_percent);
    end
    mismatches_o <= mismatches;
    pending_o    <= readings_due.size();
  end

endmodule

### test/battery_soc_estimator_tb.sv
`timescale 1ns / 1ps

// Top of the estimator bench: clock, reset, sample and bound-register
// stimulus, random back-pressure on the readings, and the verdict. All
// prediction and comparison lives in bse_reading_checker.
module battery_soc_estimator_tb;
  import bse_pkg::*;

  // Shapes of one window of samples.
  typedef enum int {
    WIN_LEVEL,   // samples around a drifting cell voltage, a few dropouts
    WIN_DEAD,    // every sample failed
    WIN_WILD,    // full 16-bit noise
    WIN_PEGGED,  // stuck near full scale
    WIN_SPARSE   // mostly failed, each sample live with a 15% chance
  } window_kind_e;

  localparam int SAMPLES           = SAMPLES_DEFAULT;
  localparam int WINDOWS_PER_PHASE = 8;
  localparam int PHASES            = 8;
  // settle time after the last predicted reading, in clock cycles
  localparam int SETTLE_CYCLES     = 64;
  localparam int DRAIN_LIMIT       = 20000;

  logic clk_i;
  logic rst_ni;

  bse_sample_if sample_if ();
  bse_cfg_if    cfg_if ();
  bse_result_if result_if ();

  int errors;
  int pending;
  int gap_pct;    // chance per cycle that the sample source holds off
  int stall_pct;  // chance per cycle that the reading sink is not ready
  int level_mv;   // center of the LEVEL windows, walks between windows

  battery_soc_estimator #(
    .SAMPLES_PER_READING(SAMPLES)
  ) uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .cfg_i    (cfg_if),
    .result_o (result_if)
  );

  bse_reading_checker #(
    .SAMPLES_PER_READING(SAMPLES)
  ) reading_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_mon   (sample_if),
    .cfg_mon      (cfg_if),
    .result_mon   (result_if),
    .mismatches_o (errors),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Reading sink: random stalls at the rate of the current phase.
  always @(posedge clk_i) begin
    result_if.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("[battery_soc_estimator] ERROR");
    $finish;
  end

  // One sample request; valid stays up afterwards so back-to-back requests
  // never drop it.
  task automatic send_sample(input logic [MV_W-1:0] mv);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid     <= 1'b1;
    sample_if.sample_mv <= mv;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
  endtask

  task automatic send_window(input window_kind_e kind);
    logic [MV_W-1:0] mv;
    for (int s = 0; s < SAMPLES; s++) begin
      case (kind)
        WIN_LEVEL:  mv = ($urandom_range(99) < 8) ? '0 :
                         MV_W'(level_mv + int'($urandom_range(60)) - 30);
        WIN_DEAD:   mv = '0;
        WIN_WILD:   mv = MV_W'($urandom_range(16'hFFFF));
        WIN_PEGGED: mv = ($urandom_range(3) == 0) ? '0 :
                         MV_W'(16'hFFFF - $urandom_range(1));
        default:    mv = ($urandom_range(99) < 15) ? MV_W'($urandom_range(5000, 2000)) : '0;
      endcase
      send_sample(mv);
    end
  endtask

  // Weighted pick; mostly realistic windows so the slew logic sees long
  // runs of valid readings.
  task automatic send_random_window();
    int roll;
    roll = $urandom_range(99);
    if ($urandom_range(9) == 0) level_mv = $urandom_range(4600, 2400);
    else level_mv = level_mv + int'($urandom_range(200)) - 100;
    if (level_mv < 2300) level_mv = 2300;
    if (level_mv > 4700) level_mv = 4700;
    if (roll < 66)      send_window(WIN_LEVEL);
    else if (roll < 74) send_window(WIN_DEAD);
    else if (roll < 84) send_window(WIN_WILD);
    else if (roll < 92) send_window(WIN_PEGGED);
    else                send_window(WIN_SPARSE);
  endtask

  task automatic cfg_put(input logic [IDX_W-1:0] idx, input logic [MV_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  // Both bounds, sometimes followed by a write to an unused index that the
  // block must ignore. Valid drops once at the end of the burst.
  task automatic apply_bounds(input logic [MV_W-1:0] lo, input logic [MV_W-1:0] hi);
    cfg_put(REG_MIN_MV, lo);
    cfg_put(REG_MAX_MV, hi);
    if ($urandom_range(1) == 1)
      cfg_put(IDX_W'($urandom_range({IDX_W{1'b1}}, REG_MAX_MV + 1)),
              MV_W'($urandom_range(16'hFFFF)));
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every predicted reading has come out, then let the back end
  // go quiet. First edge is needed so the checker's count covers the last
  // request.
  task automatic drain();
    sample_if.valid <= 1'b0;
    @(posedge clk_i);
    for (int w = 0; w < DRAIN_LIMIT && pending != 0; w++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    rst_ni              <= 1'b0;
    sample_if.valid     <= 1'b0;
    sample_if.sample_mv <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= '0;
    cfg_if.data         <= '0;
    gap_pct   = 0;
    stall_pct = 0;
    level_mv  = 3800;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < PHASES; p++) begin
      // idle pattern rotates: none, source gaps, sink stalls, light both
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 48; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 48; end
        default: begin gap_pct = 12; stall_pct = 12; end
      endcase

      // bounds only change with the pipe empty
      if (p != 0) drain();
      case (p)
        0: ;                                        // reset bounds 2500..4500
        1: apply_bounds(16'd0, 16'hFFFF);           // everything plausible
        2: apply_bounds(16'd4000, 16'd3000);        // crossed: all invalid
        3: apply_bounds(16'hFFFF, 16'hFFFF);        // only full scale passes
        4: apply_bounds(16'd0, 16'd0);              // only dead windows pass
        5: apply_bounds(16'd3300, 16'd4300);
        6: apply_bounds(MV_W'($urandom_range(3600, 1500)), MV_W'($urandom_range(6000, 3700)));
        default: apply_bounds(16'd2500, 16'd4500);
      endcase

      if (p == 0) begin
        // all samples failed: average 0, below the floor
        send_window(WIN_DEAD);
        // full-scale sample plus tiny ones: average far above the ceiling
        send_sample(16'hFFFF);
        repeat (SAMPLES - 1) send_sample(16'd1);
        // first valid reading, above the top knee: 100 taken as is
        repeat (SAMPLES) send_sample(16'd4300);
      end

      repeat (WINDOWS_PER_PHASE) send_random_window();
    end

    drain();
    if (pending != 0) $display("%0d readings never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("[battery_soc_estimator] OK");
    end else begin
      $display("[battery_soc_estimator] ERROR");
    end
    $finish;
  end

endmodule
